// ----- rtl/fda_pkg.sv -----
// Package: constants, microcode encoding and control store for float_to_decimal_ascii.
`timescale 1ns / 1ps
package fda_pkg;

    // Format and range constants
    localparam int MAX_FRACTION_DIGITS = 16;
    localparam int EXP_BIAS            = 127;
    localparam int MANT_BITS           = 23;
    localparam int EXP_TOO_LARGE       = 31;
    localparam int EXP_TOO_SMALL       = -23;
    localparam logic [23:0] FRAC_MASK  = 24'hffffff;
    localparam logic [23:0] HIDDEN_BIT = 24'h800000;

    localparam int FRAC_BITS   = 24;
    localparam int IPART_BITS  = 31;
    localparam int BCD_DIGITS  = 10;
    localparam int BCD_BITS    = 4 * BCD_DIGITS;
    // mantissa shifted left by (exponent - EXP_TOO_SMALL), at most 53 places
    localparam int SHIFT_MAX   = EXP_TOO_LARGE - 1 + MANT_BITS;
    localparam int WIDE_BITS   = FRAC_BITS + SHIFT_MAX;
    localparam int SHAMT_BITS  = 6;

    localparam logic [4:0] DIGITS_RESET = 5'd6;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_POINT = 8'h2e;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

    // Step addresses
    localparam int PC_BITS = 4;
    typedef logic [PC_BITS-1:0] t_pc;
    localparam t_pc PC_IDLE   = 4'd0;
    localparam t_pc PC_INIT   = 4'd1;
    localparam t_pc PC_DABBLE = 4'd2;
    localparam t_pc PC_SIGN   = 4'd3;
    localparam t_pc PC_SKIP   = 4'd4;
    localparam t_pc PC_IDIG   = 4'd5;
    localparam t_pc PC_POINT  = 4'd6;
    localparam t_pc PC_FDIG   = 4'd7;
    localparam t_pc PC_DONE   = 4'd8;
    localparam t_pc PC_ERR    = 4'd9;

    // Datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE   = 4'd0;
    localparam t_op OP_LOAD   = 4'd1;
    localparam t_op OP_INIT   = 4'd2;
    localparam t_op OP_DABBLE = 4'd3;
    localparam t_op OP_SIGN   = 4'd4;
    localparam t_op OP_SKIP   = 4'd5;
    localparam t_op OP_IDIG   = 4'd6;
    localparam t_op OP_POINT  = 4'd7;
    localparam t_op OP_FDIG   = 4'd8;
    localparam t_op OP_ERR    = 4'd9;

    // Jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond C_NEXT     = 3'd0;  // never jump
    localparam t_cond C_ALWAYS   = 3'd1;
    localparam t_cond C_NACC     = 3'd2;  // no item accepted
    localparam t_cond C_BIG      = 3'd3;  // exponent too large
    localparam t_cond C_CNT_NZ   = 3'd4;
    localparam t_cond C_LEAD     = 3'd5;  // leading zero digit still skippable
    localparam t_cond C_DZERO    = 3'd6;  // no fraction digits requested
    localparam t_cond C_CNT_MORE = 3'd7;  // more than one fraction digit left

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Control store
    function automatic t_uword ucode_rom(t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:   w = '{op: OP_LOAD,   cond: C_NACC,     target: PC_IDLE};
            PC_INIT:   w = '{op: OP_INIT,   cond: C_BIG,      target: PC_ERR};
            PC_DABBLE: w = '{op: OP_DABBLE, cond: C_CNT_NZ,   target: PC_DABBLE};
            PC_SIGN:   w = '{op: OP_SIGN,   cond: C_NEXT,     target: PC_IDLE};
            PC_SKIP:   w = '{op: OP_SKIP,   cond: C_LEAD,     target: PC_SKIP};
            PC_IDIG:   w = '{op: OP_IDIG,   cond: C_CNT_NZ,   target: PC_IDIG};
            PC_POINT:  w = '{op: OP_POINT,  cond: C_DZERO,    target: PC_IDLE};
            PC_FDIG:   w = '{op: OP_FDIG,   cond: C_CNT_MORE, target: PC_FDIG};
            PC_DONE:   w = '{op: OP_NONE,   cond: C_ALWAYS,   target: PC_IDLE};
            PC_ERR:    w = '{op: OP_ERR,    cond: C_ALWAYS,   target: PC_IDLE};
            default:   w = '{op: OP_NONE,   cond: C_ALWAYS,   target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/fda_if.sv -----
// Interfaces: input word channel and output character channel.
`timescale 1ns / 1ps
interface fda_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;

    modport source (output valid, output float_bits, input ready);
    modport sink   (input valid, input float_bits, output ready);
endinterface

interface fda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

// ----- rtl/float_to_decimal_ascii.sv -----
// Top level: single-precision float to decimal ASCII text, microcoded sequencer.
`timescale 1ns / 1ps
// Usage
//   i_in  : one item is a raw IEEE-754 single-precision word (float_bits),
//           taken when valid and ready are both high. Ready is high only
//           while the sequencer sits at its idle step.
//   o_out : one item per ASCII character: optional '-', integer digits
//           without leading zeros ('0' for none), '.', then the configured
//           number of truncated fraction digits. Exponents of 31 or more
//           (huge, infinity, NaN) give one item whose character is 0.
//   i_cfg_we / i_cfg_data : write digits_after_point (reset 6); values
//           above MAX_FRACTION_DIGITS saturate. Write only while idle.
// Sequence
//   Ready stays low from acceptance until the program is back at idle: init,
//   31 double-dabble steps, sign, 11 steps of leading-zero scan and integer
//   digits, point, D digits, done (no done step when the digit count D is
//   0); a too-large item runs init and error. First character: '-', else the
//   leading digit; from it on, one character per cycle unless output stalls.
// Reset and stall
//   Synchronous active-low reset returns the sequencer to idle, drops any
//   pending output item and restores the digit count to 6. A stalled
//   receiver holds the output register; the step that wants to emit waits.
module float_to_decimal_ascii #(
    parameter int MAX_FRACTION_DIGITS = fda_pkg::MAX_FRACTION_DIGITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [4:0]       i_cfg_data,
    fda_in_if.sink           i_in,
    fda_out_if.source        o_out
);

    // Counter must hold 30 (dabble), 9 (digit scan) and the digit limit.
    localparam int CNT_MAX = (MAX_FRACTION_DIGITS > 32) ? MAX_FRACTION_DIGITS : 32;
    localparam int CW      = $clog2(CNT_MAX + 1);

    localparam int FB = fda_pkg::FRAC_BITS;
    localparam int IB = fda_pkg::IPART_BITS;
    localparam int BB = fda_pkg::BCD_BITS;
    localparam int WB = fda_pkg::WIDE_BITS;

    // Sequencer and datapath registers
    fda_pkg::t_pc    r_pc, n_pc;
    logic [IB-1:0]   r_ipart, n_ipart;
    logic [FB-1:0]   r_frac, n_frac;
    logic [BB-1:0]   r_bcd, n_bcd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_neg, n_neg;
    logic            r_big, n_big;
    logic [4:0]      r_digits;
    logic            r_ov, n_ov;
    logic [7:0]      r_ch, n_ch;

    fda_pkg::t_uword w_uw;
    logic            w_accept;
    logic            w_emit;
    logic            w_stall;
    logic            w_cond;
    logic            w_lead;
    logic [CW-1:0]   w_dcount;

    // Input decode
    logic [7:0]                       w_exp;
    logic                             w_too_small;
    logic                             w_too_big;
    logic [fda_pkg::SHAMT_BITS-1:0]   w_shamt;
    logic [FB-1:0]                    w_mant;
    logic [WB-1:0]                    w_wide;

    // Arithmetic helpers
    logic [BB-1:0]   w_bcd_adj;
    logic [FB+3:0]   w_times10;

    assign i_in.ready      = (r_pc == fda_pkg::PC_IDLE);
    assign w_accept        = i_in.valid && i_in.ready;
    assign o_out.valid     = r_ov;
    assign o_out.character = r_ch;

    assign w_uw = fda_pkg::ucode_rom(r_pc);

    // Place the binary point: the value is mant * 2^(exp-150); shift the
    // mantissa so its low 24 bits of the upper window are the fraction.
    assign w_exp       = i_in.float_bits[30:23];
    assign w_too_big   = w_exp >= 8'(fda_pkg::EXP_BIAS + fda_pkg::EXP_TOO_LARGE);
    assign w_too_small = w_exp < 8'(fda_pkg::EXP_BIAS + fda_pkg::EXP_TOO_SMALL);
    assign w_shamt     = fda_pkg::SHAMT_BITS'(
                             w_exp - 8'(fda_pkg::EXP_BIAS + fda_pkg::EXP_TOO_SMALL));
    assign w_mant      = fda_pkg::HIDDEN_BIT | {1'b0, i_in.float_bits[22:0]};
    assign w_wide      = {{(WB-FB){1'b0}}, w_mant} << w_shamt;

    // Fraction digit count, saturated at the parameter
    assign w_dcount = ({{(CW-5){1'b0}}, r_digits} > CW'(MAX_FRACTION_DIGITS))
                    ? CW'(MAX_FRACTION_DIGITS) : {{(CW-5){1'b0}}, r_digits};

    // Double-dabble correction: add 3 to every BCD digit of 5 or more
    always_comb begin
        for (int d = 0; d < fda_pkg::BCD_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_bcd_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    // frac * 10 as shift-and-add; top nibble is the next digit
    assign w_times10 = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0};

    assign w_lead = (r_bcd[BB-1 -: 4] == 4'd0) && (r_cnt != '0);

    // Emit request of the current step
    always_comb begin
        unique case (w_uw.op)
            fda_pkg::OP_SIGN:  w_emit = r_neg;
            fda_pkg::OP_IDIG,
            fda_pkg::OP_POINT,
            fda_pkg::OP_FDIG,
            fda_pkg::OP_ERR:   w_emit = 1'b1;
            default:           w_emit = 1'b0;
        endcase
    end

    // Hold the step while the output register is full and not drained
    assign w_stall = w_emit && r_ov && !o_out.ready;

    // Jump condition
    always_comb begin
        unique case (w_uw.cond)
            fda_pkg::C_NEXT:     w_cond = 1'b0;
            fda_pkg::C_ALWAYS:   w_cond = 1'b1;
            fda_pkg::C_NACC:     w_cond = !w_accept;
            fda_pkg::C_BIG:      w_cond = r_big;
            fda_pkg::C_CNT_NZ:   w_cond = (r_cnt != '0);
            fda_pkg::C_LEAD:     w_cond = w_lead;
            fda_pkg::C_DZERO:    w_cond = (w_dcount == '0);
            fda_pkg::C_CNT_MORE: w_cond = (r_cnt > CW'(1));
            default:             w_cond = 1'b0;
        endcase
    end

    // Step counter
    always_comb begin
        if (w_stall) begin
            n_pc = r_pc;
        end else if (w_cond) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = r_pc + fda_pkg::t_pc'(1);
        end
    end

    // Datapath driven by the control word
    always_comb begin
        n_ipart = r_ipart;
        n_frac  = r_frac;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_big   = r_big;
        n_ch    = r_ch;
        if (!w_stall) begin
            unique case (w_uw.op)
                fda_pkg::OP_LOAD: begin
                    if (w_accept) begin
                        n_neg = i_in.float_bits[31] && (i_in.float_bits[30:0] != 31'd0);
                        n_big = w_too_big;
                        if (w_too_small || w_too_big) begin
                            n_ipart = '0;
                            n_frac  = '0;
                        end else begin
                            n_ipart = w_wide[WB-1 -: IB];
                            n_frac  = w_wide[WB-IB-1 -: FB];
                        end
                    end
                end
                fda_pkg::OP_INIT: begin
                    n_bcd = '0;
                    n_cnt = CW'(IB - 1);
                end
                fda_pkg::OP_DABBLE: begin
                    // shift one integer bit into the corrected BCD
                    n_bcd   = {w_bcd_adj[BB-2:0], r_ipart[IB-1]};
                    n_ipart = {r_ipart[IB-2:0], 1'b0};
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - CW'(1);
                    end
                end
                fda_pkg::OP_SIGN: begin
                    n_cnt = CW'(fda_pkg::BCD_DIGITS - 1);
                    // leave a waiting character alone when there is no sign
                    if (r_neg) begin
                        n_ch = fda_pkg::CH_MINUS;
                    end
                end
                fda_pkg::OP_SKIP: begin
                    // drop leading zero digits, keep at least the last one
                    if (w_lead) begin
                        n_bcd = {r_bcd[BB-5:0], 4'd0};
                        n_cnt = r_cnt - CW'(1);
                    end
                end
                fda_pkg::OP_IDIG: begin
                    n_ch  = {fda_pkg::CH_DIGIT_HI, r_bcd[BB-1 -: 4]};
                    n_bcd = {r_bcd[BB-5:0], 4'd0};
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - CW'(1);
                    end
                end
                fda_pkg::OP_POINT: begin
                    n_ch  = fda_pkg::CH_POINT;
                    n_cnt = w_dcount;
                end
                fda_pkg::OP_FDIG: begin
                    n_ch   = {fda_pkg::CH_DIGIT_HI, w_times10[FB+3 -: 4]};
                    n_frac = w_times10[FB-1:0] & fda_pkg::FRAC_MASK;
                    n_cnt  = r_cnt - CW'(1);
                end
                fda_pkg::OP_ERR: begin
                    n_ch = fda_pkg::CH_NUL;
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: load on emit, clear when taken
    always_comb begin
        if (w_emit && !w_stall) begin
            n_ov = 1'b1;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= fda_pkg::PC_IDLE;
            r_ov     <= 1'b0;
            r_digits <= fda_pkg::DIGITS_RESET;
        end else begin
            r_pc <= n_pc;
            r_ov <= n_ov;
            if (i_cfg_we) begin
                r_digits <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ipart <= n_ipart;
        r_frac  <= n_frac;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_neg   <= n_neg;
        r_big   <= n_big;
        r_ch    <= n_ch;
    end

`ifndef SYNTHESIS
    // A blocked emit step must not advance
    a_stall_holds_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> $stable(r_pc))
        else $error("sequencer advanced while output stalled");

    // An accepted item starts the conversion program
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_pc == fda_pkg::PC_INIT))
        else $error("accepted item did not start at init step");

    // Integer digits are valid BCD and within the ten-digit window
    a_idig_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == fda_pkg::PC_IDIG) |-> (r_bcd[BB-1 -: 4] <= 4'd9)
                                       && (r_cnt <= CW'(fda_pkg::BCD_DIGITS - 1)))
        else $error("integer digit out of range");
`endif

endmodule

// ----- verif/tb_float_to_decimal_ascii.sv -----
// Testbench for float_to_decimal_ascii: directed words, then random words checked char by char.
`timescale 1ns / 1ps
module tb_float_to_decimal_ascii;

    // Cycles without any accepted item before the run is declared hung.
    // The worst honest streak is the long receiver hold-off plus one item.
    localparam int WATCHDOG_LIMIT = 4000;
    // Receiver hold-off that fills the block and stalls its input.
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 300;
    // Cycles to let the sequencer get back to idle before a register write.
    localparam int SETTLE_CYCLES   = 4;
    // Tail after the last character: one full item with the longest digit count.
    localparam int TAIL_CYCLES     = 70;
    localparam int PHASE_COUNT     = 8;
    localparam int WORDS_PER_PHASE = 54;

    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef enum logic [1:0] {
        CASE_PREDICT,    // expected text comes from the predictor
        CASE_TEXT,       // expected text typed in the table
        CASE_TOO_LARGE   // one NUL item
    } t_case_kind;

    typedef struct {
        logic [31:0] bits;
        t_case_kind  kind;
        string       text;
    } t_word_case;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [4:0] i_cfg_data;

    fda_in_if  word_ch ();
    fda_out_if char_ch ();

    float_to_decimal_ascii i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (word_ch),
        .o_out      (char_ch)
    );

    // Characters still owed by the block, oldest first.
    logic [7:0] pending_chars[$];
    t_word_case directed_cases[$];
    // Our copy of digits_after_point, as last written.
    logic [4:0] digits_setting;
    int         mismatch_count = 0;
    int         chars_seen     = 0;
    int         quiet_cycles   = 0;
    // Phase with no idling on either side.
    bit         no_idle        = 1'b0;
    logic [7:0] want_char;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Expand one float word into its decimal text and queue the characters.
    function automatic void predict_text(input logic [31:0] bits, input logic [4:0] digits);
        int          exponent;
        logic [31:0] mant;
        logic [31:0] ipart;
        logic [31:0] frac;
        logic [7:0]  dec_digits[10];
        int          ndec;
        int          count;
        exponent = int'(bits[30:23]) - fda_pkg::EXP_BIAS;
        mant     = {9'd0, 1'b1, bits[22:0]};
        ipart    = '0;
        frac     = '0;
        ndec     = 0;
        // Huge, infinity and NaN collapse to a single NUL, sign dropped.
        if (exponent >= fda_pkg::EXP_TOO_LARGE) begin
            pending_chars.push_back(fda_pkg::CH_NUL);
            return;
        end
        // Below the smallest shown exponent everything stays zero.
        if (exponent >= fda_pkg::EXP_TOO_SMALL) begin
            if (exponent >= fda_pkg::MANT_BITS) begin
                ipart = mant << (exponent - fda_pkg::MANT_BITS);
            end else if (exponent >= 0) begin
                ipart = mant >> (fda_pkg::MANT_BITS - exponent);
                frac  = (mant << (exponent + 1)) & {8'd0, fda_pkg::FRAC_MASK};
            end else begin
                frac  = mant >> (-(exponent + 1));
            end
        end
        // Negative zero has no sign; tiny negatives keep theirs.
        if (bits[31] && (bits[30:0] != '0)) begin
            pending_chars.push_back(fda_pkg::CH_MINUS);
        end
        if (ipart == '0) begin
            pending_chars.push_back(CH_ZERO);
        end else begin
            while (ipart != '0) begin
                dec_digits[ndec] = CH_ZERO + 8'(ipart % 10);
                ipart = ipart / 10;
                ndec++;
            end
            while (ndec > 0) begin
                ndec--;
                pending_chars.push_back(dec_digits[ndec]);
            end
        end
        pending_chars.push_back(fda_pkg::CH_POINT);
        // Digit counts above the maximum saturate; digits are truncated.
        count = (int'(digits) > fda_pkg::MAX_FRACTION_DIGITS)
              ? fda_pkg::MAX_FRACTION_DIGITS : int'(digits);
        for (int i = 0; i < count; i++) begin
            frac = frac * 10;
            pending_chars.push_back(CH_ZERO + 8'(frac >> fda_pkg::FRAC_BITS));
            frac = frac & {8'd0, fda_pkg::FRAC_MASK};
        end
    endfunction

    function automatic void add_case(input logic [31:0] bits, input t_case_kind kind,
                                     input string text);
        t_word_case c;
        c.bits = bits;
        c.kind = kind;
        c.text = text;
        directed_cases.push_back(c);
    endfunction

    // Often zero, as often short, now and then long.
    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    // Bias the exponent toward the printable range so most words run the
    // whole digit path; keep a share of huge, tiny and fully random words.
    function automatic logic [31:0] random_word();
        int         r;
        logic [7:0] biased;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            biased = 8'($urandom_range(fda_pkg::EXP_BIAS + fda_pkg::EXP_TOO_SMALL,
                                       fda_pkg::EXP_BIAS + fda_pkg::EXP_TOO_LARGE - 1));
        end else if (r < 80) begin
            biased = 8'($urandom_range(fda_pkg::EXP_BIAS + fda_pkg::EXP_TOO_LARGE, 255));
        end else if (r < 90) begin
            biased = 8'($urandom_range(0, fda_pkg::EXP_BIAS + fda_pkg::EXP_TOO_SMALL - 1));
        end else begin
            return $urandom;
        end
        return {1'($urandom), biased, 23'($urandom)};
    endfunction

    // Offer one word; return at the edge where it is accepted, valid still high.
    task automatic send_word(input logic [31:0] bits);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            word_ch.valid      <= 1'b0;
            word_ch.float_bits <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        word_ch.valid      <= 1'b1;
        word_ch.float_bits <= bits;
        do @(posedge i_clk); while (!word_ch.ready);
    endtask

    // Drop valid, wait for every owed character, then let the block settle.
    task automatic drain(input int settle);
        word_ch.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_digits(input logic [4:0] value);
        drain(SETTLE_CYCLES);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        digits_setting  = value;
    endtask

    // Receiver: random stalls, one long hold-off once the run is under way.
    initial begin
        bit held_off;
        int stall;
        held_off      = 1'b0;
        char_ch.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && chars_seen >= HOLD_OFF_AFTER) begin
                // Hold the output while the sender keeps offering words.
                held_off = 1'b1;
                char_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    char_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                char_ch.ready <= 1'b1;
                repeat (no_idle ? 1 : $urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Compare every accepted character with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            chars_seen++;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character %h, none expected", $time,
                         char_ch.character);
                mismatch_count++;
            end else begin
                want_char = pending_chars.pop_front();
                if (char_ch.character !== want_char) begin
                    $display("%0t: character mismatch, expected %h actual %h", $time,
                             want_char, char_ch.character);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((word_ch.valid && word_ch.ready) || (char_ch.valid && char_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Main sequence: reset, directed table at the reset digit count, then
    // random phases over several digit counts including both extremes.
    initial begin
        logic [4:0] phase_digits[PHASE_COUNT];
        logic [31:0] word;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_data         = '0;
        word_ch.valid      = 1'b0;
        word_ch.float_bits = '0;

        // Zeros, signs, tiny values, plus 1, -1 and 0.5.
        add_case(32'h0000_0000, CASE_TEXT, "0.000000");
        add_case(32'h8000_0000, CASE_TEXT, "0.000000");
        add_case(32'h0000_0001, CASE_TEXT, "0.000000");
        add_case(32'h8000_0001, CASE_TEXT, "-0.000000");
        add_case(32'h0080_0000, CASE_TEXT, "0.000000");
        add_case(32'h33ff_ffff, CASE_TEXT, "0.000000");
        add_case(32'hb3ff_ffff, CASE_TEXT, "-0.000000");
        add_case(32'h3f80_0000, CASE_TEXT, "1.000000");
        add_case(32'hbf80_0000, CASE_TEXT, "-1.000000");
        add_case(32'h3f00_0000, CASE_TEXT, "0.500000");
        // Too large: huge exponents, infinities, NaNs, either sign.
        add_case(32'h4f00_0000, CASE_TOO_LARGE, "");
        add_case(32'hcf00_0000, CASE_TOO_LARGE, "");
        add_case(32'h7f7f_ffff, CASE_TOO_LARGE, "");
        add_case(32'h7f80_0000, CASE_TOO_LARGE, "");
        add_case(32'hff80_0000, CASE_TOO_LARGE, "");
        add_case(32'h7fc0_0000, CASE_TOO_LARGE, "");
        add_case(32'hffff_ffff, CASE_TOO_LARGE, "");
        // Edges of the printable range and the shift regions.
        add_case(32'h4eff_ffff, CASE_PREDICT, "");
        add_case(32'hceff_ffff, CASE_PREDICT, "");
        add_case(32'h3400_0000, CASE_PREDICT, "");
        add_case(32'h4b00_0000, CASE_PREDICT, "");
        add_case(32'h4b7f_ffff, CASE_PREDICT, "");
        add_case(32'h3dcc_cccd, CASE_PREDICT, "");
        add_case(32'h3f7f_ffff, CASE_PREDICT, "");
        add_case(32'hc47a_0123, CASE_PREDICT, "");

        phase_digits = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd17, 5'd9, 5'd5, 5'($urandom_range(0, 31))};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        digits_setting = fda_pkg::DIGITS_RESET;

        // Directed part runs on the reset digit count.
        foreach (directed_cases[i]) begin
            send_word(directed_cases[i].bits);
            case (directed_cases[i].kind)
                CASE_TEXT: begin
                    for (int k = 0; k < directed_cases[i].text.len(); k++) begin
                        pending_chars.push_back(directed_cases[i].text[k]);
                    end
                end
                CASE_TOO_LARGE: begin
                    pending_chars.push_back(fda_pkg::CH_NUL);
                end
                default: begin
                    predict_text(directed_cases[i].bits, digits_setting);
                end
            endcase
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_digits(phase_digits[p]);
            no_idle = (p == 2);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                word = random_word();
                send_word(word);
                predict_text(word, digits_setting);
            end
        end
        no_idle = 1'b0;

        drain(TAIL_CYCLES);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
